// ===== design/bsfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsfd_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 6;
    localparam int LEN_W  = 7;

    localparam int MAX_FRAME_DEFAULT = 32;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h1A;
    localparam logic [BYTE_W-1:0] CRC_POLY         = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT         = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_MSB          = 8'h80;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic [LEN_W-1:0]  frame_length;
        logic              last_of_frame;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic take;     // line byte accepted this cycle
        logic read;     // read the frame store at the emit index
        logic advance;  // step the emit index
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic frame_good;  // accepted byte closes a nonempty frame with a good CRC
        logic at_last;     // emit index sits on the final payload byte
    } dp_status_t;

    // CRC-8, MSB first, one byte
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if ((c & CRC_MSB) != '0)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/bsfd_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bsfd_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/bsfd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bsfd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsfd_datapath
    import bsfd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT,
    localparam int AW       = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [BYTE_W-1:0] cfg_wdata,
    input  wire logic [BYTE_W-1:0] line_byte,
    input  wire ctrl_cmd_t         cmd,
    output dp_status_t             status,
    output out_item_t              item
);

    logic [BYTE_W-1:0] start_byte_reg;
    logic              prev_reg,      prev_next;
    logic              receiving_reg, receiving_next;
    logic [LEN_W-1:0]  pos_reg,       pos_next;
    logic [LEN_W-1:0]  expected_reg,  expected_next;
    logic [BYTE_W-1:0] crc_reg,       crc_next;
    logic [AW-1:0]     emit_idx_reg,  emit_idx_next;

    logic              is_start;
    logic              opens;
    logic              do_frame;
    logic              rx;
    logic [LEN_W-1:0]  pos;
    logic [BYTE_W-1:0] crc_in;
    logic [BYTE_W-1:0] crc_upd;
    logic [BYTE_W-1:0] len_adj;
    logic [LEN_W-1:0]  wr_idx;
    logic              we;
    logic              frame_good;
    logic [BYTE_W-1:0] rdata;

    assign is_start = (line_byte == start_byte_reg);
    assign len_adj  = (line_byte > start_byte_reg) ? (line_byte - 8'd1) : line_byte;
    assign wr_idx   = pos_reg - LEN_W'(1);

    always_comb
    begin
        prev_next      = prev_reg;
        opens          = 1'b0;
        do_frame       = 1'b0;
        if (cmd.take)
        begin
            if (prev_reg)
            begin
                prev_next = 1'b0;
                opens     = !is_start;
                do_frame  = 1'b1;
            end
            else if (is_start)
            begin
                prev_next = 1'b1;
            end
            else
            begin
                do_frame = 1'b1;
            end
        end
    end

    assign rx      = opens | receiving_reg;
    assign pos     = opens ? '0 : pos_reg;
    assign crc_in  = opens ? CRC_INIT : crc_reg;
    assign crc_upd = crc8_byte(crc_in, line_byte);

    always_comb
    begin
        receiving_next = receiving_reg;
        pos_next       = pos_reg;
        expected_next  = expected_reg;
        crc_next       = crc_reg;
        we             = 1'b0;
        frame_good     = 1'b0;
        if (do_frame && rx)
        begin
            if (pos == '0)
            begin
                // length byte: drop the frame when it will not fit
                if (len_adj > BYTE_W'(MAX_FRAME))
                begin
                    receiving_next = 1'b0;
                end
                else
                begin
                    receiving_next = 1'b1;
                    expected_next  = len_adj[LEN_W-1:0];
                    pos_next       = LEN_W'(1);
                    crc_next       = crc_upd;
                end
            end
            else if (pos <= expected_reg)
            begin
                we       = 1'b1;
                pos_next = pos + LEN_W'(1);
                crc_next = crc_upd;
            end
            else
            begin
                // CRC byte closes the frame either way
                receiving_next = 1'b0;
                frame_good     = (crc_in == line_byte) && (expected_reg != '0);
            end
        end
    end

    always_comb
    begin
        emit_idx_next = emit_idx_reg;
        if (frame_good)
        begin
            emit_idx_next = '0;
        end
        else if (cmd.advance)
        begin
            emit_idx_next = emit_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            prev_reg       <= 1'b0;
            receiving_reg  <= 1'b0;
            pos_reg        <= '0;
            expected_reg   <= '0;
            crc_reg        <= CRC_INIT;
            emit_idx_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_byte_reg <= cfg_wdata;
            end
            prev_reg      <= prev_next;
            receiving_reg <= receiving_next;
            pos_reg       <= pos_next;
            expected_reg  <= expected_next;
            crc_reg       <= crc_next;
            emit_idx_reg  <= emit_idx_next;
        end
    end

    bsfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (wr_idx[AW-1:0]),
        .wdata (line_byte),
        .re    (cmd.read),
        .raddr (emit_idx_reg),
        .rdata (rdata)
    );

    assign status.frame_good = frame_good;
    assign status.at_last    = ((LEN_W'(emit_idx_reg) + LEN_W'(1)) == expected_reg);

    assign item.payload_byte  = rdata;
    assign item.payload_index = IDX_W'(emit_idx_reg);
    assign item.frame_length  = expected_reg;
    assign item.last_of_frame = status.at_last;

endmodule

`default_nettype wire

// ===== design/bsfd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsfd_ctrl
    import bsfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_RX,
        ST_READ,
        ST_SHOW
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd.take    = in_ready_reg && in_valid;
        cmd.read    = (state_reg == ST_READ);
        cmd.advance = out_valid_reg && out_ready && !status.at_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RX;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_RX:
                begin
                    if (in_valid && status.frame_good)
                    begin
                        state_reg    <= ST_READ;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_READ:
                begin
                    state_reg     <= ST_SHOW;
                    out_valid_reg <= 1'b1;
                end
                ST_SHOW:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (status.at_last)
                        begin
                            state_reg    <= ST_RX;
                            in_ready_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg     <= ST_RX;
                    in_ready_reg  <= 1'b1;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/byte_stuffing_frame_decoder_crc8.sv =====
// A good frame's first payload request follows its CRC byte through the read and show states.
// Throughput: one line byte per cycle while receiving; each payload byte passes through a read
//   state and a show state, set by the frame store's registered read port, and the output can
//   stall it; input is held off until the frame's last payload byte is taken.
// Reset (rst_n low, asynchronous): drop any frame in progress, restore start byte 0x1A,
//   idle the output; the frame store keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffing_frame_decoder_crc8
    import bsfd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [BYTE_W-1:0] cfg_wdata,
    bsfd_stream_if.sink            line_in,
    bsfd_stream_if.source          frame_out
);

    // Command and status between the sequencer and the datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;
    out_item_t  item;
    in_item_t   in_item;

    assign in_item = line_in.data;

    // Sequencer: take line bytes, then walk the stored payload out one request at a time
    bsfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (line_in.valid),
        .in_ready  (line_in.ready),
        .out_valid (frame_out.valid),
        .out_ready (frame_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: unstuff, track the frame, run the CRC, hold the payload in the frame store
    bsfd_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .line_byte (in_item.line_byte),
        .cmd       (cmd),
        .status    (status),
        .item      (item)
    );

    // Store read data is registered, so the output request is driven straight from it
    assign frame_out.data = item;

endmodule

`default_nettype wire

// ===== design/bsfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsfd_checker
    import bsfd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [BYTE_W-1:0] payload_byte,
    input wire logic [IDX_W-1:0]  payload_index,
    input wire logic [LEN_W-1:0]  frame_length,
    input wire logic              last_of_frame
);

    // Input is held off for the whole payload run
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("input ready while payload pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte)
            && $stable(payload_index) && $stable(last_of_frame))
        else $error("stalled payload request changed");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (LEN_W'(payload_index) < frame_length))
        else $error("payload index beyond frame length");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_frame == ((LEN_W'(payload_index) + LEN_W'(1)) == frame_length)))
        else $error("last mark misplaced");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_frame |=> !out_valid && in_ready)
        else $error("payload run did not end after last byte");

endmodule

bind byte_stuffing_frame_decoder_crc8 bsfd_checker u_bsfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (line_in.ready),
    .out_valid     (frame_out.valid),
    .out_ready     (frame_out.ready),
    .payload_byte  (frame_out.data.payload_byte),
    .payload_index (frame_out.data.payload_index),
    .frame_length  (frame_out.data.frame_length),
    .last_of_frame (frame_out.data.last_of_frame)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bsfd_pkg::*;

    // Frame store depth of the block under test; lengths above it are dropped
    localparam int FRAME_CAP   = MAX_FRAME_DEFAULT;
    // Generous ceiling on run length, several times the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    // Length of the one long receiver hold-off, in cycles
    localparam int LONG_HOLD   = 300;
    // Cycles to let pass once drained, covering the block's own latency
    localparam int SETTLE      = 12;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_we    = 1'b0;
    logic [BYTE_W-1:0] cfg_wdata = '0;

    // Line side driver registers
    logic     drv_valid = 1'b0;
    in_item_t drv_item  = '0;
    int       send_gap  = 0;

    // Payload side receiver registers
    logic sink_ready = 1'b0;
    int   stall_left = 0;
    int   hold_left  = 0;
    bit   hold_done  = 1'b0;
    int   results_seen = 0;

    // Set only while the block is drained: runs a phase with no idling on either side
    bit no_idle = 1'b0;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Raw line bytes waiting to be offered, and payload bytes still owed by the block
    logic [BYTE_W-1:0] line_backlog[$];
    out_item_t         frame_bytes_due[$];

    // Decoder state mirrored on the testbench side
    logic [BYTE_W-1:0] start_byte_q = START_BYTE_RESET;
    bit                saw_lone_start = 1'b0;
    bit                in_frame = 1'b0;
    int                frame_pos = 0;
    int                frame_len = 0;
    logic [BYTE_W-1:0] crc_q = CRC_INIT;
    logic [BYTE_W-1:0] payload_mem [FRAME_CAP];

    // Stimulus builder state
    logic [BYTE_W-1:0] tx_start = START_BYTE_RESET;
    int                items_queued = 0;
    int                results_planned = 0;

    out_item_t got;
    out_item_t want;

    bsfd_stream_if #(.payload_t(in_item_t))  line_if ();
    bsfd_stream_if #(.payload_t(out_item_t)) frame_if ();

    assign line_if.valid  = drv_valid;
    assign line_if.data   = drv_item;
    assign frame_if.ready = sink_ready;

    byte_stuffing_frame_decoder_crc8 #(
        .MAX_FRAME (FRAME_CAP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .line_in   (line_if),
        .frame_out (frame_if)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // CRC-8, polynomial 0x31, shifted in one data bit at a time, MSB first
    // ------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        logic              fb;
        acc = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb  = acc[BYTE_W-1] ^ b[i];
            acc = {acc[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    // Mostly no gap, some short ones, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Prediction: one unstuffed frame byte, possibly opening a new frame
    // ------------------------------------------------------------------
    task automatic take_frame_byte(input logic [BYTE_W-1:0] b, input bit opens);
        int        len;
        out_item_t r;
        if (opens)
        begin
            crc_q     = CRC_INIT;
            in_frame  = 1'b1;
            frame_pos = 0;
        end
        if (in_frame)
        begin
            if (frame_pos == 0)
            begin
                // Length byte: lower it by one when it lies above the start byte
                len = int'(b);
                if (b > start_byte_q)
                begin
                    len = len - 1;
                end
                if (len > FRAME_CAP)
                begin
                    // Drop the frame; ignore everything up to the next start
                    in_frame = 1'b0;
                end
                else
                begin
                    frame_len = len;
                    frame_pos = 1;
                    crc_q     = crc8_next(crc_q, b);
                end
            end
            else if (frame_pos - 1 < frame_len)
            begin
                payload_mem[frame_pos - 1] = b;
                frame_pos = frame_pos + 1;
                crc_q     = crc8_next(crc_q, b);
            end
            else
            begin
                // CRC byte closes the frame either way; emit only on a match
                in_frame = 1'b0;
                if (crc_q == b && frame_len != 0)
                begin
                    for (int k = 0; k < frame_len; k++)
                    begin
                        r.payload_byte  = payload_mem[k];
                        r.payload_index = k[IDX_W-1:0];
                        r.frame_length  = frame_len[LEN_W-1:0];
                        r.last_of_frame = (k == frame_len - 1);
                        frame_bytes_due = {frame_bytes_due, r};
                    end
                end
            end
        end
    endtask

    // Prediction: one raw line byte, undoing the start byte stuffing
    task automatic decode_line_byte(input logic [BYTE_W-1:0] b);
        if (saw_lone_start)
        begin
            saw_lone_start = 1'b0;
            // A doubled start byte is data; anything else after a start opens a frame
            take_frame_byte(b, b != start_byte_q);
        end
        else if (b == start_byte_q)
        begin
            saw_lone_start = 1'b1;
        end
        else
        begin
            take_frame_byte(b, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic send_raw(input logic [BYTE_W-1:0] b);
        line_backlog = {line_backlog, b};
        items_queued = items_queued + 1;
    endtask

    // Stuff a data byte: double it when it equals the start byte
    task automatic send_data(input logic [BYTE_W-1:0] b);
        if (b == tx_start)
        begin
            send_raw(b);
        end
        send_raw(b);
    endtask

    // Skew payload towards the start byte and the extreme values
    function automatic logic [BYTE_W-1:0] rand_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 16)
        begin
            return tx_start;
        end
        else if (r < 26)
        begin
            return 8'h00;
        end
        else if (r < 36)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Raw length byte that the block lowers back to n
    function automatic logic [BYTE_W-1:0] length_on_line(input int n);
        if (n < tx_start)
        begin
            return n[BYTE_W-1:0];
        end
        return n[BYTE_W-1:0] + 8'd1;
    endfunction

    // Whole frame: start, length, payload, CRC; fill < 0 asks for random payload
    task automatic send_frame(input int n, input bit bad_crc, input int fill);
        logic [BYTE_W-1:0] len_raw;
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] sum;
        len_raw = length_on_line(n);
        send_raw(tx_start);
        send_raw(len_raw);
        sum = crc8_next(CRC_INIT, len_raw);
        for (int k = 0; k < n; k++)
        begin
            d = (fill < 0) ? rand_payload() : fill[BYTE_W-1:0];
            send_data(d);
            sum = crc8_next(sum, d);
        end
        if (bad_crc)
        begin
            sum = sum ^ (8'h01 << $urandom_range(0, 7));
        end
        send_data(sum);
        if (!bad_crc && n > 0 && n <= FRAME_CAP)
        begin
            results_planned = results_planned + n;
        end
    endtask

    // Length beyond the store, then a few bytes the block must ignore
    task automatic send_oversize(input int n);
        int extra;
        send_raw(tx_start);
        send_raw(length_on_line(n));
        extra = $urandom_range(0, 3);
        for (int k = 0; k < extra; k++)
        begin
            send_data(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            return FRAME_CAP;
        end
        else if (r < 20)
        begin
            return $urandom_range(9, FRAME_CAP - 1);
        end
        return $urandom_range(1, 8);
    endfunction

    // Frame cut short by a fresh start, which must abandon it
    task automatic send_cut_frame();
        int n;
        int cut;
        n   = $urandom_range(2, 8);
        cut = $urandom_range(0, n - 1);
        send_raw(tx_start);
        send_raw(length_on_line(n));
        for (int k = 0; k < cut; k++)
        begin
            send_data(rand_payload());
        end
        send_frame(pick_len(), 1'b0, -1);
    endtask

    // Mostly good frames with random content, the rest noise and broken frames
    task automatic random_phase(input int n_items, input int n_results);
        int item_goal;
        int result_goal;
        int r;
        int junk;
        item_goal   = items_queued + n_items;
        result_goal = results_planned + n_results;
        while (items_queued < item_goal || results_planned < result_goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 62)
            begin
                send_frame(pick_len(), 1'b0, -1);
            end
            else if (r < 70)
            begin
                send_frame(pick_len(), 1'b1, -1);
            end
            else if (r < 76)
            begin
                send_frame(0, 1'($urandom_range(0, 1)), -1);
            end
            else if (r < 82)
            begin
                send_oversize($urandom_range(FRAME_CAP + 1, 254));
            end
            else if (r < 90)
            begin
                send_cut_frame();
            end
            else
            begin
                junk = $urandom_range(1, 3);
                for (int k = 0; k < junk; k++)
                begin
                    send_data(8'($urandom_range(0, 255)));
                end
            end
        end
        // Close on a clean frame so no half frame spans a start byte change
        send_frame(pick_len(), 1'b0, -1);
    endtask

    // Hold the sender until every request is taken and every payload byte is back
    task automatic wait_drained();
        while (line_backlog.size() != 0 || drv_valid || frame_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_start_byte(input logic [BYTE_W-1:0] v);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        start_byte_q = v;
        tx_start     = v;
    endtask

    // ------------------------------------------------------------------
    // Line side driver: offer queued requests with random gaps between them
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            send_gap  <= 0;
        end
        else
        begin
            // Predict on the edge that takes the request
            if (drv_valid && line_if.ready)
            begin
                decode_line_byte(drv_item.line_byte);
            end
            // Hold the current request until it is taken, then advance
            if (!drv_valid || line_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap  <= send_gap - 1;
                    drv_valid <= 1'b0;
                end
                else if (line_backlog.size() != 0)
                begin
                    drv_item.line_byte <= line_backlog.pop_front();
                    drv_valid          <= 1'b1;
                    send_gap           <= no_idle ? 0 : pick_gap();
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here: start it once mid-frame while
    // the sender keeps offering, so the block backs up its input
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= 12 && frame_if.valid)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Payload side monitor: check each taken request and stall at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
        end
        else
        begin
            if (frame_if.valid && sink_ready)
            begin
                got = frame_if.data;
                if (frame_bytes_due.size() == 0)
                begin
                    $error("payload request with nothing due: payload_byte %0d index %0d",
                           got.payload_byte, got.payload_index);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (got.payload_byte !== want.payload_byte)
                    begin
                        $error("payload_byte: expected %0d, actual %0d",
                               want.payload_byte, got.payload_byte);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got.payload_index !== want.payload_index)
                    begin
                        $error("payload_index: expected %0d, actual %0d",
                               want.payload_index, got.payload_index);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got.frame_length !== want.frame_length)
                    begin
                        $error("frame_length: expected %0d, actual %0d",
                               want.frame_length, got.frame_length);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got.last_of_frame !== want.last_of_frame)
                    begin
                        $error("last_of_frame: expected %0d, actual %0d",
                               want.last_of_frame, got.last_of_frame);
                        mismatch_count = mismatch_count + 1;
                    end
                end
                results_seen = results_seen + 1;
            end

            if (hold_left > 0)
            begin
                sink_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                sink_ready <= 1'b0;
            end
            else
            begin
                sink_ready <= 1'b1;
                stall_left <= no_idle ? 0 : pick_gap();
            end
        end
    end

    // Watchdog: end a hung run as a failure
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout with %0d payload bytes still due", frame_bytes_due.size());
            $display("FAIL byte_stuffing_frame_decoder_crc8");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed frames, then random phases over several
    // start byte settings, draining the block before each register write
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Bytes outside any frame: ignore
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h55);
        // Good frames of all-ones payload, of the start byte as payload and of all-zeros payload
        send_frame(2, 1'b0, 8'hFF);
        send_frame(1, 1'b0, int'(tx_start));
        send_frame(1, 1'b0, 8'h00);
        // Zero length with a good and a bad CRC: nothing comes out
        send_frame(0, 1'b0, -1);
        send_frame(0, 1'b1, -1);
        // CRC mismatch: reception ends, nothing comes out
        send_frame(2, 1'b1, -1);
        // New start inside a frame: abandon the old one
        send_raw(tx_start);
        send_raw(8'd3);
        send_data(8'h11);
        send_frame(1, 1'b0, -1);
        // Length byte 0xFF and one just beyond the store: drop the frame
        send_oversize(254);
        send_oversize(FRAME_CAP + 1);

        // Every length byte is lowered with a start byte of zero
        write_start_byte(8'h00);
        random_phase(6, 4);

        write_start_byte(8'hFF);
        random_phase(6, 4);

        // No idling on either side through this phase
        write_start_byte(8'($urandom_range(1, 254)));
        no_idle = 1'b1;
        random_phase(6, 4);

        write_start_byte(START_BYTE_RESET);
        no_idle = 1'b0;
        random_phase(6, 4);

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("PASS byte_stuffing_frame_decoder_crc8");
        end
        else
        begin
            $display("FAIL byte_stuffing_frame_decoder_crc8");
        end
        $finish;
    end

endmodule
